// ===== sv/acld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acld_pkg
// Types and constants shared by the ASCII command line decoder modules.
// ----------------------------------------------------------------------------
package acld_pkg;

    typedef logic [7:0] t_byte;

    // Input item: one message byte and its end flag.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_message;
    } t_in_item;

    // Result item: one per message.
    typedef struct packed {
        logic [2:0]  command_code;
        logic [31:0] frequency_hz;
        logic [31:0] duration_value;
        logic        length_ok;
        logic        wrapped;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_SEND    = 3'd1,
        CMD_RECEIVE = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_QUERY   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        SCALE_ONE  = 2'd0,
        SCALE_KILO = 2'd1,
        SCALE_MEGA = 2'd2
    } t_scale;

    // Parsed message handed from the parser to the scaler.
    typedef struct packed {
        t_cmd        command;
        logic [31:0] freq_raw;
        t_scale      scale;
        logic [31:0] duration;
        logic        length_ok;
        logic        wrapped;
    } t_mid_item;

    localparam int unsigned MAX_LEN_DEF = 128;
    localparam logic [7:0]  MIN_LEN     = 8'd5;

    localparam int unsigned NUM_KW = 4;
    localparam int unsigned KW_MAX = 8;

    localparam t_byte KW_TEXT [NUM_KW][KW_MAX] = '{
        '{"s", "e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "c", "e", "i", "v", "e", 8'h00},
        '{"s", "t", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"q", "u", "e", "r", "y", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd4, 4'd7, 4'd4, 4'd5};
    localparam t_cmd KW_CMD [NUM_KW] = '{CMD_SEND, CMD_RECEIVE, CMD_STOP, CMD_QUERY};

    localparam logic [19:0] SCALE_KILO_VAL = 20'd1000;
    localparam logic [19:0] SCALE_MEGA_VAL = 20'd1000000;

endpackage : acld_pkg
`default_nettype wire

// ===== sv/acld_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acld_parser
// Per-byte tokenizer and decoder state; registers the parsed message.
// ----------------------------------------------------------------------------
module acld_parser
    import acld_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_mid_valid,
    input  wire logic      i_mid_ready,
    output t_mid_item      o_mid_item
);

    localparam t_byte CHAR_NUL  = 8'h00;
    localparam t_byte CHAR_US   = "_";
    localparam t_byte CHAR_ZERO = "0";
    localparam t_byte CHAR_NINE = "9";
    localparam t_byte CHAR_H    = "h";
    localparam t_byte CHAR_K    = "k";
    localparam t_byte CHAR_M    = "m";
    localparam t_byte CHAR_Z    = "z";

    typedef struct packed {
        logic [1:0]  seg;
        logic        in_tok;
        logic [3:0]  tpos;
        logic [3:0]  cand;
        logic [31:0] acc;
        logic [15:0] prev;
        logic [2:0]  unit;
        t_cmd        cmd;
        logic [31:0] freq_raw;
        t_scale      scale;
        logic [31:0] dur;
        logic        ovf;
    } t_pstate;

    localparam t_pstate P_RESET = '{
        seg: 2'd0, in_tok: 1'b0, tpos: 4'd0, cand: 4'hF, acc: 32'd0,
        prev: 16'd0, unit: 3'd0, cmd: CMD_NONE, freq_raw: 32'd1,
        scale: SCALE_ONE, dur: 32'd1, ovf: 1'b0
    };

    function automatic t_pstate finish_token(input t_pstate s);
        t_pstate r;
        r = s;
        if (s.in_tok) begin
            case (s.seg)
                2'd0: begin
                    r.cmd = CMD_NONE;
                    // descending so the first matching keyword wins
                    for (int k = NUM_KW - 1; k >= 0; k--) begin
                        if (s.cand[k] && s.tpos == KW_LEN[k]) begin
                            r.cmd = KW_CMD[k];
                        end
                    end
                end
                2'd1: begin
                    r.freq_raw = s.acc;
                    r.scale    = s.unit[2] ? SCALE_MEGA :
                                 s.unit[1] ? SCALE_KILO : SCALE_ONE;
                end
                2'd2: begin
                    r.dur = s.acc;
                end
                default: begin
                end
            endcase
            if (s.seg != 2'd3) begin
                r.seg = s.seg + 2'd1;
            end
            r.in_tok = 1'b0;
        end
        return r;
    endfunction

    function automatic t_pstate add_byte(input t_pstate s, input t_byte c);
        t_pstate     r;
        logic [35:0] v;
        r = s;
        if (!s.in_tok) begin
            r.in_tok = 1'b1;
            r.tpos   = 4'd0;
            r.cand   = 4'hF;
            r.acc    = 32'd0;
            r.prev   = 16'd0;
            r.unit   = 3'd0;
        end
        if (r.seg == 2'd0) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (r.tpos >= KW_LEN[k] || KW_TEXT[k][r.tpos[2:0]] != c) begin
                    r.cand[k] = 1'b0;
                end
            end
        end else if (r.seg != 2'd3) begin
            if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
                // acc * 10 + digit as shift-add
                v = {1'b0, r.acc, 3'b000} + {3'b000, r.acc, 1'b0}
                  + 36'(4'(c - CHAR_ZERO));
                if (|v[35:32]) begin
                    r.ovf = 1'b1;
                end
                r.acc = v[31:0];
            end
            if (c == CHAR_Z && r.prev[7:0] == CHAR_H) begin
                r.unit[0] = 1'b1;
                if (r.prev[15:8] == CHAR_K) begin
                    r.unit[1] = 1'b1;
                end
                if (r.prev[15:8] == CHAR_M) begin
                    r.unit[2] = 1'b1;
                end
            end
        end
        r.prev = {r.prev[7:0], c};
        if (r.tpos != 4'd15) begin
            r.tpos = r.tpos + 4'd1;
        end
        return r;
    endfunction

    t_pstate    r_st,    n_st;
    logic       r_nul,   n_nul;
    logic [7:0] r_count, n_count;
    logic       r_mid_valid, n_mid_valid;
    t_mid_item  r_mid_item,  n_mid_item;

    logic mid_free;
    logic take;

    assign mid_free    = !r_mid_valid || i_mid_ready;
    assign o_in_ready  = !i_in_item.end_of_message || mid_free;
    assign take        = i_in_valid && o_in_ready;
    assign o_mid_valid = r_mid_valid;
    assign o_mid_item  = r_mid_item;

    always_comb begin
        t_pstate    s;
        logic [7:0] cnt;
        logic       len_ok;
        s       = r_st;
        n_nul   = r_nul;
        cnt     = (r_count == 8'hFF) ? r_count : r_count + 8'd1;
        if (!r_nul) begin
            if (i_in_item.char_byte == CHAR_NUL) begin
                n_nul = 1'b1;
                s     = finish_token(s);
            end else if (i_in_item.char_byte == CHAR_US) begin
                s = finish_token(s);
            end else begin
                s = add_byte(s, i_in_item.char_byte);
            end
        end
        if (i_in_item.end_of_message) begin
            s = finish_token(s);
        end
        len_ok = (cnt >= MIN_LEN) && (cnt < 8'(MAX_LEN));

        if (len_ok) begin
            n_mid_item = '{command: s.cmd, freq_raw: s.freq_raw, scale: s.scale,
                           duration: s.dur, length_ok: 1'b1, wrapped: s.ovf};
        end else begin
            n_mid_item = '{command: CMD_NONE, freq_raw: 32'd1, scale: SCALE_ONE,
                           duration: 32'd1, length_ok: 1'b0, wrapped: 1'b0};
        end

        // a message ends: start the next one from reset
        if (i_in_item.end_of_message) begin
            n_st    = P_RESET;
            n_nul   = 1'b0;
            n_count = 8'd0;
        end else begin
            n_st    = s;
            n_count = cnt;
        end

        if (mid_free) begin
            n_mid_valid = take && i_in_item.end_of_message;
        end else begin
            n_mid_valid = r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= P_RESET;
            r_nul       <= 1'b0;
            r_count     <= 8'd0;
            r_mid_valid <= 1'b0;
        end else begin
            if (take) begin
                r_st    <= n_st;
                r_nul   <= n_nul;
                r_count <= n_count;
            end
            r_mid_valid <= n_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_free && take) begin
            r_mid_item <= n_mid_item;
        end
    end

endmodule : acld_parser
`default_nettype wire

// ===== sv/acld_scaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acld_scaler
// Applies the kHz/MHz scale to the frequency and registers the result item.
// ----------------------------------------------------------------------------
module acld_scaler
    import acld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_mid_valid,
    output logic            o_mid_ready,
    input  wire t_mid_item  i_mid_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item
);

    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;
    logic [19:0] scale_val;
    logic [51:0] prod;

    assign o_mid_ready = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        case (i_mid_item.scale)
            SCALE_KILO: scale_val = SCALE_KILO_VAL;
            SCALE_MEGA: scale_val = SCALE_MEGA_VAL;
            default:    scale_val = 20'd1;
        endcase
        prod = i_mid_item.freq_raw * scale_val;
        n_out_item = '{
            command_code:   3'(i_mid_item.command),
            frequency_hz:   prod[31:0],
            duration_value: i_mid_item.duration,
            length_ok:      i_mid_item.length_ok,
            wrapped:        i_mid_item.wrapped || (|prod[51:32])
        };
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_mid_ready) begin
            r_out_valid <= i_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_ready && i_mid_valid) begin
            r_out_item <= n_out_item;
        end
    end

endmodule : acld_scaler
`default_nettype wire

// ===== sv/ascii_command_line_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_command_line_decoder_unit
// Decodes an underscore-separated ASCII command line into command, frequency
// and duration.
// ----------------------------------------------------------------------------
// The unit takes one message byte per item, with end_of_message marking the
// final byte, and gives one result item per message. A new byte is accepted
// every clock cycle; the only stall is on a final byte while a previous
// result is still held in the pipe. A final byte passes to its result through
// an input register, the parser stage (token split, keyword match, shift-add
// digit accumulation, unit detection) and the scaler stage (one 32x20
// constant multiply for kHz/MHz). Tokens are split at underscores,
// empty tokens are skipped, and a NUL ends parsing while later bytes still
// count toward the length. Messages shorter than 5 bytes or of MAX_LEN bytes
// or more give command 0, frequency 1, duration 1 and length_ok 0.
// Arithmetic wraps modulo 2^32 and raises wrapped.
module ascii_command_line_decoder_unit
    import acld_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      parse_ready;
    logic      mid_valid;
    logic      mid_ready;
    t_mid_item mid_item;

    // Input register: refill whenever the held item moves on.
    assign o_in_ready = !r_in_valid || parse_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Parser: advance tokenizer state on every byte, emit on the last one.
    acld_parser #(
        .MAX_LEN (MAX_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_in_valid),
        .o_in_ready  (parse_ready),
        .i_in_item   (r_in_item),
        .o_mid_valid (mid_valid),
        .i_mid_ready (mid_ready),
        .o_mid_item  (mid_item)
    );

    // Scaler: apply the unit multiplier and hold the result item.
    acld_scaler u_scaler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .o_mid_ready (mid_ready),
        .i_mid_item  (mid_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule : ascii_command_line_decoder_unit
`default_nettype wire
